[design/dtlf_pkg.sv]
// shared types, sizes and codes for the descriptor table with lowest-free allocation
// no dependencies; every other design file but dtlf_ram refers to this package by scoped names
package dtlf_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths of the item and result
    localparam int OPC_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int LOW_W   = 7;
    localparam int HOST_W  = 31;
    localparam int LIVE_W  = 7;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = HOST_W + 1;

    // free-slot search is split into groups of eight slots
    localparam int GRP_SIZE  = 8;
    localparam int GRP_POS_W = 3;
    localparam int GRP_NUM   = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    // operation codes
    localparam logic [OPC_W-1:0] OP_ADOPT  = 2'd0;
    localparam logic [OPC_W-1:0] OP_CLOSE  = 2'd1;
    localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADDESC = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [SLOT_W-1:0] slot_number;
        logic signed [31:0] host_descriptor;
        logic [LOW_W-1:0]  lowest_allowed;
        logic              exec_close_flag;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_result;
        logic [HOST_W-1:0] host_result;
        logic              flag_result;
        logic [LIVE_W-1:0] live_entries;
    } t_result;

    // outcome of the lowest-free search
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_find;

endpackage

[design/dtlf_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module dtlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/dtlf_free_find.sv]
// two-stage search for the lowest free slot at or above a minimum
// depends on dtlf_pkg for table geometry and the t_find result type
module dtlf_free_find (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic [dtlf_pkg::TABLE_DEPTH-1:0] i_map,
    input  logic [dtlf_pkg::LOW_W-1:0]       i_lowest,
    output dtlf_pkg::t_find                  o_find
);

    localparam int NBITS = dtlf_pkg::GRP_NUM * dtlf_pkg::GRP_SIZE;

    logic [NBITS-1:0]                 free_vec;
    logic [dtlf_pkg::GRP_NUM-1:0]     grp_any;
    logic [dtlf_pkg::GRP_POS_W-1:0]   grp_pos [dtlf_pkg::GRP_NUM];
    logic [dtlf_pkg::GRP_NUM-1:0]     r_grp_any;
    logic [dtlf_pkg::GRP_POS_W-1:0]   r_grp_pos [dtlf_pkg::GRP_NUM];

    // candidate slots: empty, inside the table and not below the minimum
    always_comb begin
        free_vec = '0;
        free_vec[dtlf_pkg::TABLE_DEPTH-1:0] = ~i_map;
        for (int i = 0; i < NBITS; i++) begin
            if (i < int'(i_lowest)) begin
                free_vec[i] = 1'b0;
            end
        end
    end

    // lowest candidate within each group of eight
    always_comb begin
        for (int g = 0; g < dtlf_pkg::GRP_NUM; g++) begin
            grp_any[g] = 1'b0;
            grp_pos[g] = '0;
            for (int b = dtlf_pkg::GRP_SIZE - 1; b >= 0; b--) begin
                if (free_vec[g * dtlf_pkg::GRP_SIZE + b]) begin
                    grp_any[g] = 1'b1;
                    grp_pos[g] = dtlf_pkg::GRP_POS_W'(b);
                end
            end
        end
    end

    // group results held for the second stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp_any <= grp_any;
            for (int g = 0; g < dtlf_pkg::GRP_NUM; g++) begin
                r_grp_pos[g] <= grp_pos[g];
            end
        end
    end

    // lowest group with a candidate
    always_comb begin
        o_find = '0;
        for (int g = dtlf_pkg::GRP_NUM - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                o_find.found = 1'b1;
                o_find.idx   = dtlf_pkg::IDX_W'(g * dtlf_pkg::GRP_SIZE + int'(r_grp_pos[g]));
            end
        end
    end

endmodule

[design/descriptor_table_lowest_free_core.sv]
// top level of the descriptor table: handshake, occupancy map, live count, result register
// depends on dtlf_pkg, dtlf_ram and dtlf_free_find
//
// One item is taken at a time: an item accepted at one edge (start high, busy low)
// keeps busy high for the next cycle, while the entry memory delivers the addressed
// slot and the first stage of the free-slot search settles; at the following edge the
// occupancy map, live count and entry memory are updated and the result is registered.
// The result then sits on o_result with o_done high for exactly one cycle, and that cycle
// may also accept the next item. The receiver cannot stall, so results must be taken
// when o_done is seen. The entry memory needs no clearing pass after reset: an entry is
// only read through a set occupancy bit, and those bits clear at reset at once.
module descriptor_table_lowest_free_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dtlf_pkg::t_item   i_item,
    output logic              o_done,
    output dtlf_pkg::t_result o_result
);

    localparam int IDX_W  = dtlf_pkg::IDX_W;
    localparam int CNT_W  = dtlf_pkg::CNT_W;
    localparam int SLOT_W = dtlf_pkg::SLOT_W;
    localparam int LIVE_W = dtlf_pkg::LIVE_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                           r_state;
    dtlf_pkg::t_item                  r_item;
    logic [dtlf_pkg::TABLE_DEPTH-1:0] r_map;
    logic [dtlf_pkg::TABLE_DEPTH-1:0] n_map;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_done;
    dtlf_pkg::t_result                r_result;
    dtlf_pkg::t_result                n_result;

    logic                             accept;
    logic [IDX_W+SLOT_W-1:0]          in_slot_wide;
    logic [IDX_W+SLOT_W-1:0]          cur_slot_wide;
    logic [IDX_W+SLOT_W-1:0]          found_wide;
    logic [CNT_W+LIVE_W-1:0]          count_wide;
    logic [IDX_W-1:0]                 cur_slot_idx;
    logic                             slot_in_range;
    logic                             wr_en;
    logic                             map_set;
    logic                             map_clr;
    logic [dtlf_pkg::ENTRY_W-1:0]     rd_entry;
    dtlf_pkg::t_find                  find;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_EXEC);

    // slot numbers fitted to the table index width
    assign in_slot_wide  = {{IDX_W{1'b0}}, i_item.slot_number};
    assign cur_slot_wide = {{IDX_W{1'b0}}, r_item.slot_number};
    assign cur_slot_idx  = cur_slot_wide[IDX_W-1:0];
    assign slot_in_range = int'(r_item.slot_number) < dtlf_pkg::TABLE_DEPTH;
    assign found_wide    = {{SLOT_W{1'b0}}, find.idx};

    // entry store; an item's write comes in the cycle after its read, and busy keeps
    // the next item's read behind this item's write
    dtlf_ram #(
        .WIDTH (dtlf_pkg::ENTRY_W),
        .DEPTH (dtlf_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (find.idx),
        .i_wdata ({r_item.exec_close_flag, r_item.host_descriptor[dtlf_pkg::HOST_W-1:0]}),
        .i_re    (accept),
        .i_raddr (in_slot_wide[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // lowest free slot at or above the item's minimum
    dtlf_free_find u_free_find (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_map    (r_map),
        .i_lowest (i_item.lowest_allowed),
        .o_find   (find)
    );

    // operation decode and result
    always_comb begin
        n_result             = '0;
        n_result.status      = dtlf_pkg::STAT_OK;
        n_result.slot_result = r_item.slot_number;
        wr_en                = 1'b0;
        map_set              = 1'b0;
        map_clr              = 1'b0;
        case (r_item.opcode)
            dtlf_pkg::OP_ADOPT: begin
                if (r_item.host_descriptor[31]) begin
                    n_result.status = dtlf_pkg::STAT_INVALID;
                end else if (!find.found) begin
                    n_result.status = dtlf_pkg::STAT_NOSPACE;
                end else begin
                    n_result.slot_result = found_wide[SLOT_W-1:0];
                    wr_en                = 1'b1;
                    map_set              = 1'b1;
                end
            end
            dtlf_pkg::OP_CLOSE, dtlf_pkg::OP_LOOKUP: begin
                if (!slot_in_range || !r_map[cur_slot_idx]) begin
                    n_result.status = dtlf_pkg::STAT_BADDESC;
                end else begin
                    n_result.host_result = rd_entry[dtlf_pkg::HOST_W-1:0];
                    n_result.flag_result = rd_entry[dtlf_pkg::HOST_W];
                    map_clr              = (r_item.opcode == dtlf_pkg::OP_CLOSE);
                end
            end
            default: begin
                n_result.status = dtlf_pkg::STAT_INVALID;
            end
        endcase

        // occupancy and live count after this item
        n_map = r_map;
        if (map_set) begin
            n_map[find.idx] = 1'b1;
        end
        if (map_clr) begin
            n_map[cur_slot_idx] = 1'b0;
        end
        n_count = r_count + CNT_W'(map_set) - CNT_W'(map_clr);
        count_wide = {{LIVE_W{1'b0}}, n_count};
        n_result.live_entries = count_wide[LIVE_W-1:0];
    end

    // sequencer, table state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_map   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item  <= i_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_map    <= n_map;
                    r_count  <= n_count;
                    r_result <= n_result;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[design/dtlf_checker.sv]
// port-level checks on the descriptor table top level, attached by bind
// depends on dtlf_pkg and descriptor_table_lowest_free_core
module dtlf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input dtlf_pkg::t_result o_result
);

    // an accepted item is worked on while busy is high and reported in the cycle after
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ##1 o_done))
        else $error("accepted item not reported two cycles later");

    // the work cycle never stretches
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // a result only follows a work cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding work cycle");

    // failed items carry no host descriptor or flag
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != dtlf_pkg::STAT_OK))
            |-> ((o_result.host_result == '0) && !o_result.flag_result))
        else $error("failed item reports host data");

endmodule

bind descriptor_table_lowest_free_core dtlf_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

[tb/tb_descriptor_table_lowest_free_core.sv]
// self-checking testbench for descriptor_table_lowest_free_core
// depends on dtlf_pkg and the core; an in-bench table model predicts every result
`timescale 1ns / 1ps

module tb_descriptor_table_lowest_free_core;

    // opcode value that the block does not define
    localparam logic [dtlf_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int DEPTH      = dtlf_pkg::TABLE_DEPTH;
    localparam int SLOT_W     = dtlf_pkg::SLOT_W;
    localparam int LOW_W      = dtlf_pkg::LOW_W;
    localparam int HOST_W     = dtlf_pkg::HOST_W;
    localparam int OPC_W      = dtlf_pkg::OPC_W;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    dtlf_pkg::t_item   i_item;
    logic              o_done;
    dtlf_pkg::t_result o_result;

    // table model: entry contents, occupancy and live count
    logic [HOST_W-1:0] model_host [DEPTH]     = '{default: '0};
    logic              model_flag [DEPTH]     = '{default: 1'b0};
    logic              model_occupied [DEPTH] = '{default: 1'b0};
    int                model_live = 0;

    dtlf_pkg::t_result expected_results[$];
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;

    descriptor_table_lowest_free_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // apply one item to the table model and return what the block should report
    function automatic dtlf_pkg::t_result predict_table_op(dtlf_pkg::t_item it);
        dtlf_pkg::t_result r;
        int idx;
        r = '0;
        r.slot_result = it.slot_number;
        if (it.opcode == dtlf_pkg::OP_ADOPT) begin
            if (it.host_descriptor[31]) begin
                r.status = dtlf_pkg::STAT_INVALID;
            end else begin
                idx = int'(it.lowest_allowed);
                while (idx < DEPTH && model_occupied[idx])
                    idx++;
                if (idx >= DEPTH) begin
                    r.status = dtlf_pkg::STAT_NOSPACE;
                end else begin
                    model_host[idx]     = it.host_descriptor[HOST_W-1:0];
                    model_flag[idx]     = it.exec_close_flag;
                    model_occupied[idx] = 1'b1;
                    model_live++;
                    r.status      = dtlf_pkg::STAT_OK;
                    r.slot_result = idx[SLOT_W-1:0];
                end
            end
        end else if (it.opcode == dtlf_pkg::OP_CLOSE || it.opcode == dtlf_pkg::OP_LOOKUP) begin
            if (int'(it.slot_number) >= DEPTH || !model_occupied[it.slot_number]) begin
                r.status = dtlf_pkg::STAT_BADDESC;
            end else begin
                r.status      = dtlf_pkg::STAT_OK;
                r.host_result = model_host[it.slot_number];
                r.flag_result = model_flag[it.slot_number];
                if (it.opcode == dtlf_pkg::OP_CLOSE) begin
                    model_occupied[it.slot_number] = 1'b0;
                    model_live--;
                end
            end
        end else begin
            r.status = dtlf_pkg::STAT_INVALID;
        end
        r.live_entries = model_live[dtlf_pkg::LIVE_W-1:0];
        return r;
    endfunction

    // predict on acceptance, compare every result with the oldest expectation
    always @(posedge i_clk) begin
        dtlf_pkg::t_result want;
        if (o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: actual %p", $time, o_result);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_result.status);
                if (o_result.slot_result !== want.slot_result)
                    $display("%0t: slot_result mismatch: expected %0d actual %0d",
                             $time, want.slot_result, o_result.slot_result);
                if (o_result.host_result !== want.host_result)
                    $display("%0t: host_result mismatch: expected %h actual %h",
                             $time, want.host_result, o_result.host_result);
                if (o_result.flag_result !== want.flag_result)
                    $display("%0t: flag_result mismatch: expected %b actual %b",
                             $time, want.flag_result, o_result.flag_result);
                if (o_result.live_entries !== want.live_entries)
                    $display("%0t: live_entries mismatch: expected %0d actual %0d",
                             $time, want.live_entries, o_result.live_entries);
                if (o_result !== want)
                    mismatch_count++;
            end
        end
        if (i_rst_n && start && !busy)
            expected_results.push_back(predict_table_op(i_item));
    end

    // watchdog on cycles with no accepted item and no result
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("descriptor_table_lowest_free_core regression: fail");
            $finish;
        end
    end

    function automatic dtlf_pkg::t_item make_item(logic [OPC_W-1:0] op,
                                                  logic [SLOT_W-1:0] slot,
                                                  logic [31:0] host, logic [LOW_W-1:0] low,
                                                  logic flag);
        dtlf_pkg::t_item it;
        it.opcode          = op;
        it.slot_number     = slot;
        it.host_descriptor = host;
        it.lowest_allowed  = low;
        it.exec_close_flag = flag;
        return it;
    endfunction

    // hold start high with the item until the block takes it
    task automatic send_item(dtlf_pkg::t_item it);
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // sender gap with noise on the item bus
    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start  = 1'b0;
        i_item = dtlf_pkg::t_item'($bits(dtlf_pkg::t_item)'({$urandom, $urandom}));
        repeat (n - 1) @(negedge i_clk);
    endtask

    // an occupied slot if there is one, else any slot
    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int base;
        int k;
        base = $urandom_range(DEPTH - 1);
        for (k = 0; k < DEPTH; k++)
            if (model_occupied[(base + k) % DEPTH])
                return SLOT_W'((base + k) % DEPTH);
        return SLOT_W'(base);
    endfunction

    function automatic dtlf_pkg::t_item random_item(int adopt_pct, int close_pct);
        int pick;
        logic [31:0] host;
        logic [LOW_W-1:0] low;
        logic [SLOT_W-1:0] slot;
        logic flag;
        pick = $urandom_range(99);
        host = $urandom;
        flag = 1'($urandom_range(1));
        if ($urandom_range(9) != 0)
            host[31] = 1'b0;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: low = '0;
            5, 6, 7:       low = LOW_W'($urandom_range(DEPTH - 1));
            8:             low = LOW_W'($urandom_range(DEPTH - 1, DEPTH - 8));
            default:       low = LOW_W'($urandom_range(127));
        endcase
        slot = ($urandom_range(4) == 0) ? SLOT_W'($urandom) : pick_live_slot();
        if (pick < adopt_pct)
            return make_item(dtlf_pkg::OP_ADOPT, SLOT_W'($urandom), host, low, flag);
        else if (pick < adopt_pct + close_pct)
            return make_item(dtlf_pkg::OP_CLOSE, slot, host, low, flag);
        else if (pick < 97)
            return make_item(dtlf_pkg::OP_LOOKUP, slot, host, low, flag);
        else
            return make_item(OP_UNUSED, SLOT_W'($urandom), host, low, flag);
    endfunction

    // extremes of the fields and each special case
    task automatic test_directed_cases();
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd0, 32'd5, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd63, 32'h7FFF_FFFF, 7'd0, 1'b1));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd0, 32'd0, 7'd63, 1'b1));
        // top slot taken: no space above minimum
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd17, 32'd7, 7'd63, 1'b0));
        // minimum at or beyond depth
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd5, 32'd1, 7'd64, 1'b0));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd63, 32'h1234_5678, 7'd127, 1'b1));
        // negative host descriptors
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd9, 32'h8000_0000, 7'd0, 1'b1));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd63, 32'hFFFF_FFFF, 7'd127, 1'b1));
        send_item(make_item(dtlf_pkg::OP_LOOKUP, 6'd1, 32'hFFFF_FFFF, 7'd127, 1'b1));
        send_item(make_item(dtlf_pkg::OP_LOOKUP, 6'd63, 32'd0, 7'd0, 1'b0));
        // empty slot
        send_item(make_item(dtlf_pkg::OP_LOOKUP, 6'd2, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_CLOSE, 6'd2, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_CLOSE, 6'd0, 32'd0, 7'd0, 1'b0));
        // freed low slot is reused first
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd0, 32'd9, 7'd0, 1'b1));
        send_item(make_item(OP_UNUSED, 6'd63, 32'hFFFF_FFFF, 7'd127, 1'b1));
        send_item(make_item(OP_UNUSED, 6'd0, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_CLOSE, 6'd63, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_LOOKUP, 6'd63, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_CLOSE, 6'd1, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_CLOSE, 6'd1, 32'd0, 7'd0, 1'b0));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd0, 32'h7FFF_FFFE, 7'd62, 1'b0));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd0, 32'h0000_0001, 7'd62, 1'b1));
        send_item(make_item(dtlf_pkg::OP_ADOPT, 6'd0, 32'd3, 7'd62, 1'b1));
        send_item(make_item(dtlf_pkg::OP_LOOKUP, 6'd62, 32'd0, 7'd0, 1'b0));
    endtask

    // alternating fill-heavy and drain-heavy phases with random sender gaps
    task automatic test_fill_and_drain();
        int round;
        int n;
        for (round = 0; round < 6; round++) begin
            for (n = 0; n < 100; n++) begin
                if (round % 2 == 0)
                    send_item(random_item(70, 10));
                else
                    send_item(random_item(15, 65));
                if ($urandom_range(3) == 0)
                    idle_cycles($urandom_range(19, 1));
            end
        end
    endtask

    // back-to-back items with no gaps at the end of the run
    task automatic test_back_to_back();
        int n;
        for (n = 0; n < 150; n++)
            send_item(random_item(45, 30));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_fill_and_drain();
        test_back_to_back();

        // drain outstanding results, then a few quiet cycles
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("descriptor_table_lowest_free_core regression: pass");
        else
            $display("descriptor_table_lowest_free_core regression: fail");
        $finish;
    end

endmodule
